// ----- hdl/position_pid_actuator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// position_pid_actuator_unit_assert
// Assertion macros for the actuator position controller. Simulation only.
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_ACTUATOR_UNIT_ASSERT_SVH
`define POSITION_PID_ACTUATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication or plain property
`define PPA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// trigger in this cycle, consequence in the next
`define PPA_ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define PPA_ASSERT(name, prop, msg)
`define PPA_ASSERT_NEXT(name, trig, cons, msg)
`endif
`endif

// ----- hdl/pidact_pkg.sv -----
// ----------------------------------------------------------------------------
// pidact_pkg
// Shared types and constants of the actuator position controller.
// ----------------------------------------------------------------------------
package pidact_pkg;

	localparam int ADC_BITS     = 10;
	localparam int LENGTH_BITS  = 12;
	localparam int GAIN_BITS    = 32;
	localparam int ACC_I_BITS   = 32;
	localparam int DRIVE_BITS   = 9;

	// apb register file
	localparam int ADDR_BITS    = 5;
	localparam int DATA_BITS    = 32;
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_POT_MIN    = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_POT_MAX    = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_MIN = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_LENGTH_MAX = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_P     = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_I     = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_D     = 3'd6;

	localparam logic [ADC_BITS-1:0]    POT_MIN_RST    = 10'd0;
	localparam logic [ADC_BITS-1:0]    POT_MAX_RST    = 10'd1023;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MIN_RST = 12'd0;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX_RST = 12'd4095;
	localparam logic [GAIN_BITS-1:0]   GAIN_P_RST     = 32'h0001_0000;
	localparam logic [GAIN_BITS-1:0]   GAIN_I_RST     = 32'h0000_0000;
	localparam logic [GAIN_BITS-1:0]   GAIN_D_RST     = 32'h0000_0000;

	// operation codes
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_SET_TARGET = 2'd1;
	localparam logic [1:0] OP_STOP       = 2'd2;

	// datapath widths
	localparam int DIV_BITS     = ADC_BITS + LENGTH_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
	localparam int NUM_BITS     = ADC_BITS + LENGTH_BITS + 2;
	localparam int LENW_BITS    = DIV_BITS + 2;
	localparam int ERR_BITS     = LENGTH_BITS + 1;
	localparam int DERR_BITS    = ERR_BITS + 1;
	localparam int PROD_BITS    = GAIN_BITS + ACC_I_BITS + 1;
	localparam int TERM_BITS    = 42;
	localparam int ACC_BITS     = 43;
	localparam int FRAC_BITS    = 16;

	localparam logic signed [PROD_BITS-1:0] TERM_POS = 65'sh100_0000_0000;
	localparam logic signed [PROD_BITS-1:0] TERM_NEG = -65'sh100_0000_0000;
	localparam logic [ACC_BITS-1:0]         ROUND_HALF = 43'd32768;
	localparam logic [7:0]                  DRIVE_MAX  = 8'd255;

	typedef struct packed {
		logic [1:0]             op;
		logic [ADC_BITS-1:0]    pot_sample;
		logic [LENGTH_BITS-1:0] target_length;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_BITS-1:0] drive;
		logic                         fault;
		logic [LENGTH_BITS-1:0]       measured_length;
	} out_item_t;

	typedef struct packed {
		logic [ADC_BITS-1:0]    pot_min;
		logic [ADC_BITS-1:0]    pot_max;
		logic [LENGTH_BITS-1:0] length_min;
		logic [LENGTH_BITS-1:0] length_max;
		logic [GAIN_BITS-1:0]   gain_p;
		logic [GAIN_BITS-1:0]   gain_i;
		logic [GAIN_BITS-1:0]   gain_d;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_DIV,
		ST_CHECK,
		ST_MUL,
		ST_ACC,
		ST_ROUND,
		ST_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef enum logic [1:0] {
		RES_HOLD,
		RES_STOP,
		RES_FAULT,
		RES_PID
	} res_t;

	typedef struct packed {
		logic  cap_in;
		logic  set_target;
		logic  map_en;
		logic  div_step;
		logic  check_en;
		logic  mul_en;
		term_t mul_term;
		logic  acc_clear;
		logic  acc_en;
		res_t  res_set;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic empty_range;
		logic len_bad;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/pidact_regs.sv -----
// ----------------------------------------------------------------------------
// pidact_regs
// APB register file holding calibration, limits and gains.
// ----------------------------------------------------------------------------
module pidact_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pidact_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [pidact_pkg::DATA_BITS-1:0]    pwdata,
	output logic [pidact_pkg::DATA_BITS-1:0]    prdata,
	output logic                                pready,
	output pidact_pkg::cfg_t                    cfg
);

	localparam int AdcBits = pidact_pkg::ADC_BITS;
	localparam int LenBits = pidact_pkg::LENGTH_BITS;
	localparam int DataBits = pidact_pkg::DATA_BITS;
	localparam int AddrBits = pidact_pkg::ADDR_BITS;

	pidact_pkg::cfg_t                      cfg_q;
	logic [pidact_pkg::REG_IDX_BITS-1:0]   idx;
	logic                                  wr_en;

	assign idx    = paddr[AddrBits-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pot_min    <= pidact_pkg::POT_MIN_RST;
			cfg_q.pot_max    <= pidact_pkg::POT_MAX_RST;
			cfg_q.length_min <= pidact_pkg::LENGTH_MIN_RST;
			cfg_q.length_max <= pidact_pkg::LENGTH_MAX_RST;
			cfg_q.gain_p     <= pidact_pkg::GAIN_P_RST;
			cfg_q.gain_i     <= pidact_pkg::GAIN_I_RST;
			cfg_q.gain_d     <= pidact_pkg::GAIN_D_RST;
		end else if (wr_en) begin
			unique case (idx)
				pidact_pkg::REG_POT_MIN:    cfg_q.pot_min    <= pwdata[AdcBits-1:0];
				pidact_pkg::REG_POT_MAX:    cfg_q.pot_max    <= pwdata[AdcBits-1:0];
				pidact_pkg::REG_LENGTH_MIN: cfg_q.length_min <= pwdata[LenBits-1:0];
				pidact_pkg::REG_LENGTH_MAX: cfg_q.length_max <= pwdata[LenBits-1:0];
				pidact_pkg::REG_GAIN_P:     cfg_q.gain_p     <= pwdata;
				pidact_pkg::REG_GAIN_I:     cfg_q.gain_i     <= pwdata;
				pidact_pkg::REG_GAIN_D:     cfg_q.gain_d     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pidact_pkg::REG_POT_MIN:    prdata = DataBits'(cfg_q.pot_min);
			pidact_pkg::REG_POT_MAX:    prdata = DataBits'(cfg_q.pot_max);
			pidact_pkg::REG_LENGTH_MIN: prdata = DataBits'(cfg_q.length_min);
			pidact_pkg::REG_LENGTH_MAX: prdata = DataBits'(cfg_q.length_max);
			pidact_pkg::REG_GAIN_P:     prdata = cfg_q.gain_p;
			pidact_pkg::REG_GAIN_I:     prdata = cfg_q.gain_i;
			pidact_pkg::REG_GAIN_D:     prdata = cfg_q.gain_d;
			default:                    prdata = '0;
		endcase
	end

endmodule

// ----- hdl/pidact_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidact_ctrl
// Sequencer: decodes items and steps the datapath through map, divide,
// check, multiply-accumulate and round.
// ----------------------------------------------------------------------------
module pidact_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_op,
	input  pidact_pkg::sts_t  sts,
	output pidact_pkg::cmd_t  cmd
);

	localparam int CntBits = pidact_pkg::DIV_CNT_BITS;
	localparam logic [CntBits-1:0] DivLast = CntBits'(pidact_pkg::DIV_BITS - 1);

	pidact_pkg::ctrl_state_t state_q, state_d;
	logic [CntBits-1:0]      cnt_q, cnt_d;
	pidact_pkg::term_t       term_q, term_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidact_pkg::ST_IDLE;
			cnt_q   <= '0;
			term_q  <= pidact_pkg::TERM_P;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			term_q  <= term_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		term_d       = term_q;
		cmd          = '0;
		cmd.mul_term = term_q;
		cmd.res_set  = pidact_pkg::RES_HOLD;
		req_ready    = 1'b0;
		unique case (state_q)
			pidact_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.cap_in = 1'b1;
					unique case (req_op)
						pidact_pkg::OP_TICK: begin
							// empty pot range faults without mapping
							if (sts.empty_range) begin
								cmd.res_set = pidact_pkg::RES_FAULT;
								state_d     = pidact_pkg::ST_EMIT;
							end else begin
								state_d = pidact_pkg::ST_MAP;
							end
						end
						pidact_pkg::OP_SET_TARGET: cmd.set_target = 1'b1;
						pidact_pkg::OP_STOP: begin
							cmd.res_set = pidact_pkg::RES_STOP;
							state_d     = pidact_pkg::ST_EMIT;
						end
						default: ;
					endcase
				end
			end
			pidact_pkg::ST_MAP: begin
				cmd.map_en = 1'b1;
				cnt_d      = '0;
				state_d    = pidact_pkg::ST_DIV;
			end
			pidact_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DivLast) begin
					state_d = pidact_pkg::ST_CHECK;
				end
			end
			pidact_pkg::ST_CHECK: begin
				if (sts.len_bad) begin
					cmd.res_set = pidact_pkg::RES_FAULT;
					state_d     = pidact_pkg::ST_EMIT;
				end else begin
					cmd.check_en  = 1'b1;
					cmd.acc_clear = 1'b1;
					term_d        = pidact_pkg::TERM_P;
					state_d       = pidact_pkg::ST_MUL;
				end
			end
			pidact_pkg::ST_MUL: begin
				// the product of the previous term is accumulated here
				cmd.mul_en = 1'b1;
				cmd.acc_en = (term_q != pidact_pkg::TERM_P);
				unique case (term_q)
					pidact_pkg::TERM_P: term_d = pidact_pkg::TERM_I;
					pidact_pkg::TERM_I: term_d = pidact_pkg::TERM_D;
					default:            state_d = pidact_pkg::ST_ACC;
				endcase
			end
			pidact_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = pidact_pkg::ST_ROUND;
			end
			pidact_pkg::ST_ROUND: begin
				cmd.res_set = pidact_pkg::RES_PID;
				state_d     = pidact_pkg::ST_EMIT;
			end
			pidact_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = pidact_pkg::ST_IDLE;
				end
			end
			default: state_d = pidact_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/pidact_dp.sv -----
// ----------------------------------------------------------------------------
// pidact_dp
// Datapath: pot-to-length mapping with a radix-2 divider, PID state,
// one shared multiplier, term accumulator and output register.
// ----------------------------------------------------------------------------
module pidact_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pidact_pkg::cfg_t       cfg,
	input  pidact_pkg::cmd_t       cmd,
	output pidact_pkg::sts_t       sts,
	input  pidact_pkg::in_item_t   req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output pidact_pkg::out_item_t  rsp_data
);

	localparam int AdcBits   = pidact_pkg::ADC_BITS;
	localparam int LenBits   = pidact_pkg::LENGTH_BITS;
	localparam int DivBits   = pidact_pkg::DIV_BITS;
	localparam int NumBits   = pidact_pkg::NUM_BITS;
	localparam int LenWBits  = pidact_pkg::LENW_BITS;
	localparam int ErrBits   = pidact_pkg::ERR_BITS;
	localparam int DerrBits  = pidact_pkg::DERR_BITS;
	localparam int GainBits  = pidact_pkg::GAIN_BITS;
	localparam int IntBits   = pidact_pkg::ACC_I_BITS;
	localparam int ProdBits  = pidact_pkg::PROD_BITS;
	localparam int TermBits  = pidact_pkg::TERM_BITS;
	localparam int AccBits   = pidact_pkg::ACC_BITS;
	localparam int FracBits  = pidact_pkg::FRAC_BITS;
	localparam int DriveBits = pidact_pkg::DRIVE_BITS;
	localparam int RndBits   = AccBits - FracBits;

	// item and pid state
	logic [AdcBits-1:0]         sample_q;
	logic [LenBits-1:0]         target_q;
	logic signed [IntBits-1:0]  integral_q;
	logic signed [ErrBits-1:0]  prev_err_q;
	logic signed [ErrBits-1:0]  err_q;
	logic signed [DerrBits-1:0] derr_q;
	logic [LenBits-1:0]         len_q;

	// divider
	logic [DivBits-1:0]         quo_q;
	logic [AdcBits-1:0]         rem_q;
	logic [AdcBits-1:0]         dsr_q;
	logic                       neg_q;

	// multiply and accumulate
	logic signed [ProdBits-1:0] prod_s1;
	logic signed [AccBits-1:0]  acc_q;

	// result and output
	logic signed [DriveBits-1:0] res_drive_q;
	logic                        res_fault_q;
	logic [LenBits-1:0]          res_len_q;
	logic                        rsp_valid_q;
	pidact_pkg::out_item_t       rsp_data_q;

	logic [LenBits-1:0]          tgt_clamp_c;
	logic signed [AdcBits:0]     sdiff_c;
	logic signed [AdcBits:0]     den_c;
	logic signed [LenBits:0]     ldiff_c;
	logic signed [NumBits-1:0]   num_c;
	logic [NumBits-1:0]          num_mag_c;
	logic [AdcBits:0]            den_mag_c;
	logic [AdcBits:0]            trial_c;
	logic [AdcBits:0]            trial_sub_c;
	logic                        trial_ge_c;
	logic signed [LenWBits-1:0]  quo_s_c;
	logic signed [LenWBits-1:0]  len_c;
	logic signed [LenWBits-1:0]  lmin_s_c;
	logic signed [LenWBits-1:0]  lmax_s_c;
	logic signed [ErrBits-1:0]   err_c;
	logic signed [IntBits:0]     isum_c;
	logic signed [IntBits-1:0]   isat_c;
	logic signed [DerrBits-1:0]  derr_c;
	logic [GainBits-1:0]         gain_c;
	logic signed [IntBits-1:0]   opb_c;
	logic signed [TermBits-1:0]  term_c;
	logic [AccBits-1:0]          mag_c;
	logic [AccBits-1:0]          rnd_c;
	logic [RndBits-1:0]          whole_c;
	logic [7:0]                  sat_c;
	logic signed [DriveBits-1:0] drive_c;

	// set-target clamp
	always_comb begin
		priority if (req_data.target_length < cfg.length_min) begin
			tgt_clamp_c = cfg.length_min;
		end else if (req_data.target_length > cfg.length_max) begin
			tgt_clamp_c = cfg.length_max;
		end else begin
			tgt_clamp_c = req_data.target_length;
		end
	end

	// mapping numerator and divisor
	assign sdiff_c   = $signed({1'b0, sample_q}) - $signed({1'b0, cfg.pot_min});
	assign den_c     = $signed({1'b0, cfg.pot_max}) - $signed({1'b0, cfg.pot_min});
	assign ldiff_c   = $signed({1'b0, cfg.length_max}) - $signed({1'b0, cfg.length_min});
	assign num_c     = sdiff_c * ldiff_c;
	assign num_mag_c = num_c[NumBits-1] ? NumBits'(-num_c) : NumBits'(num_c);
	assign den_mag_c = den_c[AdcBits] ? (AdcBits+1)'(-den_c) : (AdcBits+1)'(den_c);

	// restoring divide, one quotient bit per step
	assign trial_c     = {rem_q, quo_q[DivBits-1]};
	assign trial_ge_c  = (trial_c >= {1'b0, dsr_q});
	assign trial_sub_c = trial_c - {1'b0, dsr_q};

	// length, range check and error
	assign quo_s_c  = $signed({2'b00, quo_q});
	assign lmin_s_c = $signed(LenWBits'(cfg.length_min));
	assign lmax_s_c = $signed(LenWBits'(cfg.length_max));
	assign len_c    = (neg_q ? -quo_s_c : quo_s_c) + lmin_s_c;
	assign err_c    = $signed({1'b0, target_q}) - $signed({1'b0, len_c[LenBits-1:0]});
	assign isum_c   = $signed({integral_q[IntBits-1], integral_q}) + (IntBits+1)'(err_c);
	assign derr_c   = DerrBits'(err_c) - DerrBits'(prev_err_q);

	always_comb begin
		// saturate the integral at the signed 32-bit limits
		if (isum_c[IntBits] != isum_c[IntBits-1]) begin
			isat_c = isum_c[IntBits] ? {1'b1, {(IntBits-1){1'b0}}} : {1'b0, {(IntBits-1){1'b1}}};
		end else begin
			isat_c = isum_c[IntBits-1:0];
		end
	end

	// shared multiplier operands
	always_comb begin
		unique case (cmd.mul_term)
			pidact_pkg::TERM_P: begin
				gain_c = cfg.gain_p;
				opb_c  = IntBits'(err_q);
			end
			pidact_pkg::TERM_I: begin
				gain_c = cfg.gain_i;
				opb_c  = integral_q;
			end
			default: begin
				gain_c = cfg.gain_d;
				opb_c  = IntBits'(derr_q);
			end
		endcase
	end

	always_comb begin
		priority if (prod_s1 > pidact_pkg::TERM_POS) begin
			term_c = pidact_pkg::TERM_POS[TermBits-1:0];
		end else if (prod_s1 < pidact_pkg::TERM_NEG) begin
			term_c = pidact_pkg::TERM_NEG[TermBits-1:0];
		end else begin
			term_c = prod_s1[TermBits-1:0];
		end
	end

	// round half away from zero, then saturate
	assign mag_c   = acc_q[AccBits-1] ? AccBits'(-acc_q) : AccBits'(acc_q);
	assign rnd_c   = mag_c + pidact_pkg::ROUND_HALF;
	assign whole_c = rnd_c[AccBits-1:FracBits];
	assign sat_c   = (|whole_c[RndBits-1:8]) ? pidact_pkg::DRIVE_MAX : whole_c[7:0];
	assign drive_c = acc_q[AccBits-1] ? -$signed({1'b0, sat_c}) : $signed({1'b0, sat_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			integral_q  <= '0;
			prev_err_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.set_target) begin
				target_q <= tgt_clamp_c;
			end
			if (cmd.check_en) begin
				integral_q <= isat_c;
				prev_err_q <= err_c;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			sample_q <= req_data.pot_sample;
		end
		if (cmd.map_en) begin
			quo_q <= num_mag_c[DivBits-1:0];
			rem_q <= '0;
			dsr_q <= den_mag_c[AdcBits-1:0];
			neg_q <= num_c[NumBits-1] ^ den_c[AdcBits];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge_c ? trial_sub_c[AdcBits-1:0] : trial_c[AdcBits-1:0];
			quo_q <= {quo_q[DivBits-2:0], trial_ge_c};
		end
		if (cmd.check_en) begin
			err_q  <= err_c;
			derr_q <= derr_c;
			len_q  <= len_c[LenBits-1:0];
		end
		if (cmd.mul_en) begin
			prod_s1 <= $signed({1'b0, gain_c}) * opb_c;
		end
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + AccBits'(term_c);
		end
		unique case (cmd.res_set)
			pidact_pkg::RES_STOP: begin
				res_drive_q <= '0;
				res_fault_q <= 1'b0;
				res_len_q   <= '0;
			end
			pidact_pkg::RES_FAULT: begin
				res_drive_q <= '0;
				res_fault_q <= 1'b1;
				res_len_q   <= '0;
			end
			pidact_pkg::RES_PID: begin
				res_drive_q <= drive_c;
				res_fault_q <= 1'b0;
				res_len_q   <= len_q;
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			rsp_data_q.drive           <= res_drive_q;
			rsp_data_q.fault           <= res_fault_q;
			rsp_data_q.measured_length <= res_len_q;
		end
	end

	assign sts.empty_range = (cfg.pot_min == cfg.pot_max);
	assign sts.len_bad     = (len_c < lmin_s_c) || (len_c > lmax_s_c);
	assign sts.out_free    = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ----- hdl/position_pid_actuator_unit.sv -----
// ----------------------------------------------------------------------------
// position_pid_actuator_unit
// Linear-actuator position PID. A set-target item stores the clamped target
// and gives no result; a stop item gives a zero result. A tick with an
// empty pot range gives a fault result; any other tick maps the pot sample
// to a length with a 22-step radix-2 divider, checks it against the limits,
// then runs the three PID terms through one shared 33x32 multiplier. One
// item is processed at a time; a finished result waits in the output
// register and the block returns to accepting items once it has been
// loaded there.
// Registers sit on an APB port at byte offsets 0x00 to 0x18.
// ----------------------------------------------------------------------------
`include "position_pid_actuator_unit_assert.svh"

module position_pid_actuator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pidact_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [pidact_pkg::DATA_BITS-1:0]  pwdata,
	output logic [pidact_pkg::DATA_BITS-1:0]  prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  pidact_pkg::in_item_t              req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output pidact_pkg::out_item_t             rsp_data
);

	pidact_pkg::cfg_t cfg;
	pidact_pkg::cmd_t cmd;
	pidact_pkg::sts_t sts;

	pidact_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidact_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_op    (req_data.op),
		.sts       (sts),
		.cmd       (cmd)
	);

	pidact_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	`PPA_ASSERT(a_no_overwrite, cmd.load_out |-> sts.out_free, "result register overwritten")
	`PPA_ASSERT(a_idle_no_load, req_ready |-> !cmd.load_out, "load while accepting items")
	`PPA_ASSERT(a_fault_zero, (rsp_valid && rsp_data.fault) |-> (rsp_data.drive == 9'sd0 && rsp_data.measured_length == '0), "fault item carries nonzero fields")
	`PPA_ASSERT_NEXT(a_target_no_busy, req_valid && req_ready && req_data.op == pidact_pkg::OP_SET_TARGET, req_ready, "set target left the block busy")

endmodule

// ----- verif/tb_position_pid_actuator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_position_pid_actuator_unit
// Self-checking bench for the actuator position controller. Items go in on a
// bursty valid/ready sender, results come back through a stalling receiver,
// and a scoreboard class predicts every result from its own copy of the
// registers, target, integral and last error. Directed items cover the field
// extremes and corner settings, then random items run under several settings.
// ----------------------------------------------------------------------------
module tb_position_pid_actuator_unit;
	import pidact_pkg::*;

	localparam logic [1:0] OP_UNDEF  = 2'd3;
	localparam longint TERM_CLIP     = 64'sd1099511627776;
	localparam longint INT32_HI      = 64'sd2147483647;
	localparam longint INT32_LO      = -64'sd2147483648;
	localparam int     SETTLE_CYCLES = 40;

	class pid_drive_checker;
		cfg_t                   regs;
		logic [LENGTH_BITS-1:0] target;
		int                     integ;
		int                     last_err;
		out_item_t              expected_q[$];
		int                     mismatches;

		function new();
			regs = '{pot_min: POT_MIN_RST, pot_max: POT_MAX_RST,
				length_min: LENGTH_MIN_RST, length_max: LENGTH_MAX_RST,
				gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST};
			target = '0;
			integ = 0;
			last_err = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
			case (idx)
				REG_POT_MIN:    regs.pot_min = val[ADC_BITS-1:0];
				REG_POT_MAX:    regs.pot_max = val[ADC_BITS-1:0];
				REG_LENGTH_MIN: regs.length_min = val[LENGTH_BITS-1:0];
				REG_LENGTH_MAX: regs.length_max = val[LENGTH_BITS-1:0];
				REG_GAIN_P:     regs.gain_p = val;
				REG_GAIN_I:     regs.gain_i = val;
				REG_GAIN_D:     regs.gain_d = val;
				default: ;
			endcase
		endfunction

		function longint clip(longint v);
			if (v > TERM_CLIP)
				return TERM_CLIP;
			if (v < -TERM_CLIP)
				return -TERM_CLIP;
			return v;
		endfunction

		function out_item_t tick_response(logic [ADC_BITS-1:0] sample);
			out_item_t o;
			longint    num, den, len, sum, q, mag, r;
			int        err, derr;
			o = '0;
			if (regs.pot_min == regs.pot_max) begin
				o.fault = 1'b1;
				return o;
			end
			num = (longint'(sample) - longint'(regs.pot_min)) *
				(longint'(regs.length_max) - longint'(regs.length_min));
			den = longint'(regs.pot_max) - longint'(regs.pot_min);
			// signed quotient, truncated toward zero
			len = num / den + longint'(regs.length_min);
			if (len < longint'(regs.length_min) || len > longint'(regs.length_max)) begin
				o.fault = 1'b1;
				return o;
			end
			err = int'(longint'(target) - len);
			sum = longint'(integ) + err;
			if (sum > INT32_HI)
				sum = INT32_HI;
			if (sum < INT32_LO)
				sum = INT32_LO;
			integ = int'(sum);
			derr = err - last_err;
			q = clip(longint'(regs.gain_p) * err) + clip(longint'(regs.gain_i) * integ) +
				clip(longint'(regs.gain_d) * derr);
			last_err = err;
			// round half away from zero, then saturate
			mag = (q < 0) ? -q : q;
			r = (mag + 32768) >>> 16;
			if (r > 255)
				r = 255;
			o.drive = DRIVE_BITS'((q < 0) ? -r : r);
			o.measured_length = LENGTH_BITS'(len);
			return o;
		endfunction

		function void note_request(in_item_t it);
			case (it.op)
				OP_SET_TARGET: begin
					if (it.target_length < regs.length_min)
						target = regs.length_min;
					else if (it.target_length > regs.length_max)
						target = regs.length_max;
					else
						target = it.target_length;
				end
				OP_STOP: expected_q.push_back(out_item_t'(0));
				OP_TICK: expected_q.push_back(tick_response(it.pot_sample));
				default: ;
			endcase
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result drive %0d fault %0b length %0d",
						$time, got.drive, got.fault, got.measured_length);
				return;
			end
			want = expected_q.pop_front();
			if (got.drive !== want.drive || got.fault !== want.fault ||
					got.measured_length !== want.measured_length) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected drive %0d fault %0b length %0d,",
						$time, want.drive, want.fault, want.measured_length,
						" got drive %0d fault %0b length %0d",
						got.drive, got.fault, got.measured_length);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	in_item_t             req_data = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	out_item_t            rsp_data;

	pid_drive_checker board = new();

	int burst_left = 0;
	bit send_steady = 1'b0;
	bit rsp_calm = 1'b0;
	int ready_left = 0;

	position_pid_actuator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always #5 clk = ~clk;

	initial begin
		#8_000_000;
		$display("tb_position_pid_actuator_unit failed");
		$finish;
	end

	// receiver: check accepted results, then pick the next ready/stall run
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			board.check_response(rsp_data);
		if (ready_left > 0) begin
			ready_left--;
		end else if (rsp_calm || !rsp_ready) begin
			rsp_ready <= 1'b1;
			ready_left = $urandom_range(1, 12);
		end else begin
			rsp_ready <= 1'b0;
			ready_left = $urandom_range(1, 6);
		end
	end

	function in_item_t item_of(logic [1:0] op, logic [ADC_BITS-1:0] pot,
			logic [LENGTH_BITS-1:0] len);
		in_item_t it;
		it.op = op;
		it.pot_sample = pot;
		it.target_length = len;
		return it;
	endfunction

	function in_item_t random_item();
		in_item_t it;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 58)
			it.op = OP_TICK;
		else if (pick < 80)
			it.op = OP_SET_TARGET;
		else if (pick < 92)
			it.op = OP_STOP;
		else
			it.op = OP_UNDEF;
		// mostly inside the calibrated range so ticks reach the pid path
		if ($urandom_range(0, 4) != 0)
			it.pot_sample = ADC_BITS'($urandom_range(board.regs.pot_min,
				board.regs.pot_max));
		else
			it.pot_sample = ADC_BITS'($urandom);
		if ($urandom_range(0, 3) != 0)
			it.target_length = LENGTH_BITS'($urandom_range(board.regs.length_min,
				board.regs.length_max));
		else
			it.target_length = LENGTH_BITS'($urandom);
		return it;
	endfunction

	function cfg_t random_setting(int kind);
		cfg_t                   c;
		logic [ADC_BITS-1:0]    pot_swap;
		logic [LENGTH_BITS-1:0] len_swap;
		c.pot_min = ADC_BITS'($urandom);
		c.pot_max = ADC_BITS'($urandom);
		c.length_min = LENGTH_BITS'($urandom);
		c.length_max = LENGTH_BITS'($urandom);
		c.gain_p = $urandom_range(0, 'h4000);
		c.gain_i = $urandom_range(0, 'h200);
		c.gain_d = $urandom_range(0, 'h8000);
		if (c.length_min > c.length_max && kind != 4) begin
			len_swap = c.length_min;
			c.length_min = c.length_max;
			c.length_max = len_swap;
		end
		if ((c.pot_min > c.pot_max) != (kind == 3) && kind != 4) begin
			pot_swap = c.pot_min;
			c.pot_min = c.pot_max;
			c.pot_max = pot_swap;
		end
		case (kind)
			0: begin
				c.pot_min = '0;
				c.pot_max = '1;
				c.length_min = '0;
				c.length_max = '1;
			end
			1: begin
				c.gain_p = '0;
				c.gain_i = '0;
				c.gain_d = '0;
			end
			2: begin
				c.gain_p = '1;
				c.gain_i = '1;
				c.gain_d = '1;
			end
			4: begin
				c.gain_p = $urandom;
				c.gain_i = $urandom;
				c.gain_d = $urandom;
			end
			default: ;
		endcase
		return c;
	endfunction

	task send_request(in_item_t it);
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		board.note_request(it);
		if (send_steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// wait for every expected result, then let a set-target item settle
	task drain();
		req_valid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task write_reg(logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.set_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task apply_setting(cfg_t c);
		drain();
		write_reg(REG_POT_MIN, DATA_BITS'(c.pot_min));
		write_reg(REG_POT_MAX, DATA_BITS'(c.pot_max));
		write_reg(REG_LENGTH_MIN, DATA_BITS'(c.length_min));
		write_reg(REG_LENGTH_MAX, DATA_BITS'(c.length_max));
		write_reg(REG_GAIN_P, c.gain_p);
		write_reg(REG_GAIN_I, c.gain_i);
		write_reg(REG_GAIN_D, c.gain_d);
		@(posedge clk);
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: full ranges, unity proportional gain
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd4095));
		send_request(item_of(OP_TICK, 10'd0, 12'd0));
		send_request(item_of(OP_TICK, 10'd1023, 12'd4095));
		send_request(item_of(OP_SET_TARGET, 10'd1023, 12'd0));
		send_request(item_of(OP_TICK, 10'd1023, 12'd0));
		send_request(item_of(OP_STOP, 10'd1023, 12'd4095));
		send_request(item_of(OP_UNDEF, 10'd1023, 12'd4095));
		send_request(item_of(OP_TICK, 10'd511, 12'd2048));

		// empty pot range, all gains at full scale
		apply_setting('{pot_min: 10'd700, pot_max: 10'd700, length_min: 12'd0,
			length_max: 12'd4095, gain_p: '1, gain_i: '1, gain_d: '1});
		send_request(item_of(OP_TICK, 10'd0, 12'd0));
		send_request(item_of(OP_TICK, 10'd700, 12'd0));
		send_request(item_of(OP_TICK, 10'd1023, 12'd0));
		send_request(item_of(OP_STOP, 10'd0, 12'd0));

		// inverted pot range, negative divisor
		apply_setting('{pot_min: 10'd1023, pot_max: 10'd0, length_min: 12'd0,
			length_max: 12'd4095, gain_p: 32'h0000_2000, gain_i: 32'h0000_0100,
			gain_d: 32'h0000_4000});
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd50));
		send_request(item_of(OP_TICK, 10'd0, 12'd0));
		send_request(item_of(OP_TICK, 10'd1023, 12'd0));
		send_request(item_of(OP_TICK, 10'd300, 12'd0));

		// inverted length limits: target clamps oddly and every tick faults
		apply_setting('{pot_min: 10'd0, pot_max: 10'd1023, length_min: 12'd3000,
			length_max: 12'd1000, gain_p: 32'h0001_0000, gain_i: '0, gain_d: '0});
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd500));
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd4095));
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd2000));
		send_request(item_of(OP_TICK, 10'd512, 12'd0));
		send_request(item_of(OP_TICK, 10'd0, 12'd0));

		// narrow limits: target clamping and samples outside the pot range
		apply_setting('{pot_min: 10'd100, pot_max: 10'd900, length_min: 12'd1000,
			length_max: 12'd2000, gain_p: '1, gain_i: 32'd1, gain_d: '1});
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd4095));
		send_request(item_of(OP_SET_TARGET, 10'd0, 12'd0));
		send_request(item_of(OP_TICK, 10'd50, 12'd0));
		send_request(item_of(OP_TICK, 10'd950, 12'd0));
		send_request(item_of(OP_TICK, 10'd100, 12'd0));

		for (int kind = 0; kind < 6; kind++) begin
			apply_setting(random_setting(kind));
			for (int chunk = 0; chunk < 3; chunk++) begin
				send_steady = ($urandom_range(0, 3) == 0);
				rsp_calm = ($urandom_range(0, 3) == 0);
				repeat (100)
					send_request(random_item());
			end
			send_steady = 1'b0;
			rsp_calm = 1'b0;
		end

		drain();
		if (board.mismatches == 0 && board.expected_q.size() == 0)
			$display("tb_position_pid_actuator_unit passed");
		else
			$display("tb_position_pid_actuator_unit failed");
		$finish;
	end

endmodule
